>>> hw/rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths and controller/datapath command types for the Booth multiplier.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int Width    = 16;
  localparam int OperandW = Width;
  localparam int ProductW = 2 * Width;
  localparam int CntW     = $clog2(Width);

  typedef struct packed {
    logic load;     // take new operands, clear accumulator
    logic step;     // one Booth add/sub and arithmetic shift
    logic capture;  // move finished product to output register
  } cmd_t;

endpackage

>>> hw/rtl/bsm_if.sv
// ----------------------------------------------------------------------------
// bsm_in_if / bsm_out_if
// Valid/ready channels carrying operand requests and product results.
// ----------------------------------------------------------------------------
interface bsm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsm_pkg::OperandW-1:0] multiplicand;
  logic signed [bsm_pkg::OperandW-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsm_pkg::ProductW-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

>>> hw/rtl/bsm_ctrl.sv
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer: accepts a request, runs Width Booth steps, hands the product to
// the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module bsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bsm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [bsm_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = bsm_pkg::CntW'(bsm_pkg::Width - 1);
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/bsm_dp.sv
// ----------------------------------------------------------------------------
// bsm_dp
// Booth radix-2 datapath: guarded accumulator, multiplier shift register,
// Q-1 bit and the output product register.
// ----------------------------------------------------------------------------
module bsm_dp (
  input  logic                                clk_i,
  input  bsm_pkg::cmd_t                       cmd_i,
  input  logic signed [bsm_pkg::OperandW-1:0] multiplicand_i,
  input  logic signed [bsm_pkg::OperandW-1:0] multiplier_i,
  output logic signed [bsm_pkg::ProductW-1:0] product_o
);

  logic [bsm_pkg::Width:0]      m_q;
  logic [bsm_pkg::Width:0]      acc_q, acc_d;
  logic [bsm_pkg::Width-1:0]    q_q, q_d;
  logic                         qm1_q, qm1_d;
  logic [bsm_pkg::Width:0]      sum;
  logic [bsm_pkg::ProductW-1:0] product_q;

  always_comb begin
    case ({q_q[0], qm1_q})
      2'b10:   sum = acc_q - m_q;
      2'b01:   sum = acc_q + m_q;
      default: sum = acc_q;
    endcase
    acc_d = {sum[bsm_pkg::Width], sum[bsm_pkg::Width:1]};
    q_d   = {sum[0], q_q[bsm_pkg::Width-1:1]};
    qm1_d = q_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= {multiplicand_i[bsm_pkg::Width-1], multiplicand_i[bsm_pkg::Width-1:0]};
      acc_q <= '0;
      q_q   <= multiplier_i[bsm_pkg::Width-1:0];
      qm1_q <= 1'b0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      q_q   <= q_d;
      qm1_q <= qm1_d;
    end
    if (cmd_i.capture) begin
      product_q <= {acc_q[bsm_pkg::Width-1:0], q_q};
    end
  end

  assign product_o = product_q;

endmodule

>>> hw/rtl/booth_signed_multiplier.sv
// ----------------------------------------------------------------------------
// booth_signed_multiplier
// A request is loaded, run for Width (16) Booth steps on the single add/shift
// unit and captured once the output register is free; only then is a new one taken.
// A finished product waits in the output register while the next request runs.
// Reset (rst_ni, async, active low) clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
module booth_signed_multiplier (
  input  logic clk_i,
  input  logic rst_ni,
  bsm_in_if.sink    in_i,
  bsm_out_if.source out_o
);

  bsm_pkg::cmd_t cmd;

  bsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bsm_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .multiplicand_i (in_i.multiplicand),
    .multiplier_i   (in_i.multiplier),
    .product_o      (out_o.product)
  );

endmodule

>>> hw/rtl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks on request/result sequencing of the Booth multiplier.
// ----------------------------------------------------------------------------
module bsm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [bsm_pkg::ProductW-1:0] product_i
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while previous one still running");

  a_busy_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##(bsm_pkg::Width) !in_ready_i)
    else $error("sequencer left busy before all Booth steps");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a finished run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(product_i)))
    else $error("stalled result dropped or changed");

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .product_i   (out_o.product)
);

>>> tb/tb_booth_signed_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_booth_signed_multiplier
// Drives signed operand requests into the Booth multiplier with random gaps,
// stalls the product channel at random, and checks every product against a
// step-by-step Booth recoding predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_booth_signed_multiplier;

  localparam int StallLimit  = 2000;
  localparam int RandomItems = 1400;

  typedef logic [bsm_pkg::OperandW-1:0]        operand_t;
  typedef logic signed [bsm_pkg::ProductW-1:0] product_t;

  class product_scoreboard;
    product_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Radix-2 Booth: (Q0, Q-1) picks sub/add/none, then arithmetic shift of {A, Q, Q-1}.
    function product_t booth_product(operand_t mcand, operand_t mplier);
      logic [bsm_pkg::OperandW:0]   acc;
      logic [bsm_pkg::OperandW:0]   m_ext;
      logic [bsm_pkg::OperandW-1:0] q;
      logic                         q_prev;
      acc    = '0;
      m_ext  = {mcand[bsm_pkg::OperandW-1], mcand};
      q      = mplier;
      q_prev = 1'b0;
      for (int i = 0; i < bsm_pkg::OperandW; i++) begin
        case ({q[0], q_prev})
          2'b10: acc = acc - m_ext;
          2'b01: acc = acc + m_ext;
          default: ;
        endcase
        q_prev = q[0];
        q      = {acc[0], q[bsm_pkg::OperandW-1:1]};
        acc    = {acc[bsm_pkg::OperandW], acc[bsm_pkg::OperandW:1]};
      end
      return {acc[bsm_pkg::OperandW-1:0], q};
    endfunction

    function void note_request(operand_t mcand, operand_t mplier);
      expected_q = {expected_q, booth_product(mcand, mplier)};
    endfunction

    function void check_product(product_t actual);
      product_t exp_prod;
      if (expected_q.size() == 0) begin
        $error("product: unexpected result, actual %0d", actual);
        errors++;
        return;
      end
      exp_prod = expected_q.pop_front();
      if (actual !== exp_prod) begin
        $error("product: expected %0d, actual %0d", exp_prod, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;
  int   idle_count;

  product_scoreboard prod_sb = new();

  bsm_in_if  in_if ();
  bsm_out_if out_if ();

  booth_signed_multiplier dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  function automatic int idle_cycles();
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic operand_t pick_operand();
    case ($urandom_range(0, 9))
      0: return operand_t'(0);
      1: return operand_t'(1);
      2: return '1;
      3: return {1'b1, {(bsm_pkg::OperandW-1){1'b0}}};
      4: return {1'b0, {(bsm_pkg::OperandW-1){1'b1}}};
      default: return operand_t'($urandom);
    endcase
  endfunction

  task automatic send_request(input operand_t mcand, input operand_t mplier);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.multiplicand <= mcand;
    in_if.multiplier   <= mplier;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // product sink with random stalls
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // request/product monitor and watchdog
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready)
      prod_sb.note_request(in_if.multiplicand, in_if.multiplier);
    if (out_if.valid && out_if.ready)
      prod_sb.check_product(out_if.product);
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    operand_t corner_a[$];
    operand_t corner_b[$];
    rst_ni             <= 1'b0;
    idle_count         <= 0;
    steady             = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.multiplicand <= '0;
    in_if.multiplier   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zeros, most negative pairs, max values, alternating bit patterns
    corner_a = '{16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0001, 16'hffff,
                 16'h0000, 16'h8000, 16'h8000, 16'h0001, 16'h5555, 16'haaaa, 16'hffff,
                 16'h7fff, 16'h1234, 16'h8000, 16'hffff};
    corner_b = '{16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 16'hffff,
                 16'h8000, 16'h0000, 16'h0001, 16'h8000, 16'haaaa, 16'h5555, 16'h5555,
                 16'h0001, 16'h0000, 16'hffff, 16'h8000};
    foreach (corner_a[i])
      send_request(corner_a[i], corner_b[i]);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0)
        steady = ($urandom_range(0, 3) == 0);
      send_request(pick_operand(), pick_operand());
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;

    while (prod_sb.pending() != 0) @(posedge clk_i);
    repeat (bsm_pkg::Width + 6) @(posedge clk_i);

    if (prod_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
